// File: src/rpt_pkg.sv
package rpt_pkg;

    // Default geometry
    localparam int unsigned RPT_MAX_SLOTS  = 16;
    localparam int unsigned RPT_INDEX_BITS = 16;

    // Fixed port widths
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned CLIENT_W = 4;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned COUNT_W  = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CHECK  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_MOVE   = 3'd5;

endpackage

// File: src/rpt_idx_mem.sv
module rpt_idx_mem
    import rpt_pkg::*;
#(
    parameter int unsigned DEPTH = RPT_MAX_SLOTS,
    parameter int unsigned WIDTH = RPT_INDEX_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/reader_pointer_table_core.sv
// Reader pointer table. Keeps up to MAX_SLOTS reader slots for one shared
// buffer, each with an active bit and a current object index. A command word
// is taken on a rising edge with start high and busy low; busy then stays
// high until the result word is shown. The result is on the o_ ports for
// exactly one cycle, flagged by o_done, and the receiver cannot stall it:
// it must take the word in that cycle. Add walks the active bits one slot
// per cycle. Check and move walk the index memory through its single
// registered read port, one slot per cycle, and compare each word once the
// port returns it. Read also uses that port when the slot is live; remove
// and write finish without a memory read. start may be raised again in the
// cycle o_done is high. max_clients is to be written through
// i_cfg_we/i_cfg_wdata only while the block is idle; the block itself does
// not enforce this. Values above MAX_SLOTS act as MAX_SLOTS, and lowering it
// below the number of allocated slots only blocks further appends. There is
// no clearing pass: slot indices are written as a slot turns active.
module reader_pointer_table_core
    import rpt_pkg::*;
#(
    parameter int unsigned MAX_SLOTS  = RPT_MAX_SLOTS,
    parameter int unsigned INDEX_BITS = RPT_INDEX_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    // command
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [CLIENT_W-1:0] i_client_id,
    input  logic [FIELD_W-1:0]  i_index_a,
    input  logic [FIELD_W-1:0]  i_index_b,
    // result
    output logic                o_done,
    output logic                o_ok,
    output logic [CLIENT_W-1:0] o_slot_given,
    output logic [FIELD_W-1:0]  o_index_out,
    output logic [COUNT_W-1:0]  o_active_count
);

    localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // control
    t_state                r_state,       n_state;
    logic [CNT_W-1:0]      r_ptr,         n_ptr;
    logic                  r_pv,          n_pv;       // read in flight
    logic [SLOT_W-1:0]     r_pptr,        n_pptr;     // slot of read in flight
    logic                  r_hit,         n_hit;
    logic [CNT_W-1:0]      r_slots_used,  n_slots_used;
    logic [MAX_SLOTS-1:0]  r_active,      n_active;
    logic [CNT_W-1:0]      r_cnt,         n_cnt;
    logic [CFG_W-1:0]      r_max_clients;
    logic                  r_done;

    // captured command
    logic [OPCODE_W-1:0]   r_op,          n_op;
    logic [CLIENT_W-1:0]   r_id,          n_id;
    logic [INDEX_BITS-1:0] r_ia,          n_ia;
    logic [INDEX_BITS-1:0] r_ib,          n_ib;

    // result payload
    logic                  r_ok;
    logic [CLIENT_W-1:0]   r_slot_given;
    logic [FIELD_W-1:0]    r_index_out;
    logic [COUNT_W-1:0]    r_active_count;

    // comb helpers
    logic                  fin;
    logic                  res_ok;
    logic [SLOT_W-1:0]     res_slot;
    logic [FIELD_W-1:0]    res_idx;
    logic [SLOT_W-1:0]     id_s;
    logic [SLOT_W-1:0]     ptr_s;
    logic [CMP_W-1:0]      limit;
    logic                  live;
    logic                  scan_more;

    // index memory port
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [INDEX_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [SLOT_W-1:0]     mem_raddr;
    logic [INDEX_BITS-1:0] mem_rdata;

    rpt_idx_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (INDEX_BITS)
    ) u_idx_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign id_s      = SLOT_W'(r_id);
    assign ptr_s     = r_ptr[SLOT_W-1:0];
    assign scan_more = (r_ptr < r_slots_used);
    // effective slot limit = min(max_clients, MAX_SLOTS)
    assign limit     = (CMP_W'(r_max_clients) < CMP_W'(MAX_SLOTS))
                       ? CMP_W'(r_max_clients) : CMP_W'(MAX_SLOTS);
    // slot is allocated and active (id < slots_used implies id < MAX_SLOTS)
    assign live      = (CMP_W'(r_id) < CMP_W'(r_slots_used)) && r_active[id_s];

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_pv         = r_pv;
        n_pptr       = r_pptr;
        n_hit        = r_hit;
        n_slots_used = r_slots_used;
        n_active     = r_active;
        n_cnt        = r_cnt;
        n_op         = r_op;
        n_id         = r_id;
        n_ia         = r_ia;
        n_ib         = r_ib;
        fin          = 1'b0;
        res_ok       = 1'b0;
        res_slot     = '0;
        res_idx      = '0;
        mem_we       = 1'b0;
        mem_waddr    = id_s;
        mem_wdata    = r_ia;
        mem_re       = 1'b0;
        mem_raddr    = ptr_s;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_opcode;
                    n_id    = i_client_id;
                    n_ia    = INDEX_BITS'(i_index_a);
                    n_ib    = INDEX_BITS'(i_index_b);
                    n_ptr   = '0;
                    n_pv    = 1'b0;
                    n_hit   = 1'b0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                unique case (r_op) inside
                    OP_ADD: begin
                        if (scan_more) begin
                            // lowest free slot among those allocated
                            if (!r_active[ptr_s]) begin
                                n_active[ptr_s] = 1'b1;
                                n_cnt           = r_cnt + 1'b1;
                                mem_we          = 1'b1;
                                mem_waddr       = ptr_s;
                                res_ok          = 1'b1;
                                res_slot        = ptr_s;
                                fin             = 1'b1;
                            end else begin
                                n_ptr = r_ptr + 1'b1;
                            end
                        end else begin
                            // none free: append if under the limit
                            if (CMP_W'(r_slots_used) < limit) begin
                                n_active[r_slots_used[SLOT_W-1:0]] = 1'b1;
                                n_cnt        = r_cnt + 1'b1;
                                n_slots_used = r_slots_used + 1'b1;
                                mem_we       = 1'b1;
                                mem_waddr    = r_slots_used[SLOT_W-1:0];
                                res_ok       = 1'b1;
                                res_slot     = r_slots_used[SLOT_W-1:0];
                            end
                            fin = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (live) begin
                            n_active[id_s] = 1'b0;
                            n_cnt          = r_cnt - 1'b1;
                            res_ok         = 1'b1;
                        end
                        fin = 1'b1;
                    end
                    OP_WRITE: begin
                        if (live) begin
                            mem_we = 1'b1;
                            res_ok = 1'b1;
                        end
                        fin = 1'b1;
                    end
                    OP_READ: begin
                        if (!r_pv) begin
                            if (live) begin
                                mem_re    = 1'b1;
                                mem_raddr = id_s;
                                n_pv      = 1'b1;
                            end else begin
                                fin = 1'b1;
                            end
                        end else begin
                            res_idx = FIELD_W'(mem_rdata);
                            res_ok  = 1'b1;
                            fin     = 1'b1;
                        end
                    end
                    OP_CHECK, OP_MOVE: begin
                        // issue one read per cycle, compare in the next cycle
                        if (scan_more) begin
                            mem_re = 1'b1;
                            n_ptr  = r_ptr + 1'b1;
                            n_pv   = 1'b1;
                            n_pptr = ptr_s;
                        end else begin
                            n_pv = 1'b0;
                        end
                        if (r_pv && r_active[r_pptr] && (mem_rdata == r_ia)) begin
                            n_hit = 1'b1;
                            if (r_op == OP_MOVE) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_pptr;
                                mem_wdata = r_ib;
                            end
                        end
                        if (!scan_more && !r_pv) begin
                            res_ok = r_hit;
                            fin    = 1'b1;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ptr         <= '0;
            r_pv          <= 1'b0;
            r_pptr        <= '0;
            r_hit         <= 1'b0;
            r_slots_used  <= '0;
            r_active      <= '0;
            r_cnt         <= '0;
            r_max_clients <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_pv         <= n_pv;
            r_pptr       <= n_pptr;
            r_hit        <= n_hit;
            r_slots_used <= n_slots_used;
            r_active     <= n_active;
            r_cnt        <= n_cnt;
            r_done       <= fin;
            if (i_cfg_we) begin
                r_max_clients <= i_cfg_wdata;
            end
        end
    end

    // command capture and result word
    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_id <= n_id;
        r_ia <= n_ia;
        r_ib <= n_ib;
        if (fin) begin
            r_ok           <= res_ok;
            r_slot_given   <= CLIENT_W'(res_slot);
            r_index_out    <= res_idx;
            r_active_count <= COUNT_W'(n_cnt);
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_slot_given   = r_slot_given;
    assign o_index_out    = r_index_out;
    assign o_active_count = r_active_count;

endmodule
